[hw/rtl/boxavg_pkg.sv]
// Shared constants and types for the 3x3 box-average downscaler.
package boxavg_pkg;

   localparam int CH_N          = 3;
   localparam int PIX_W         = 8;
   localparam int CFG_WIDTH_W   = 11;
   localparam int CFG_HEIGHT_W  = 13;
   localparam int OUT_COL_W     = 9;
   localparam int OUT_ROW_W     = 11;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int SCALE_DEF     = 3;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COLOR_MODE   = 2'd2;

   // per-pixel position flags from the scan counters
   typedef struct packed {
      logic                 last_col;
      logic                 last_row;
      logic                 col_done;
      logic                 row_done;
      logic                 col_first;
      logic                 row_first;
      logic [OUT_ROW_W-1:0] out_row;
   } flag_type;

endpackage

[hw/rtl/boxavg_scan.sv]
// Raster position counters: column/row, block phases, block indexes and edge flags.
module boxavg_scan import boxavg_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int SCALE     = SCALE_DEF,
   localparam int CW         = $clog2(MAX_WIDTH),
   localparam int PW         = $clog2(SCALE),
   localparam int RPW        = $clog2(SCALE + 1),
   localparam int BLOCK_COLS = (MAX_WIDTH + SCALE - 1) / SCALE,
   localparam int BW         = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [CFG_WIDTH_W-1:0]  cfg_width,
   input  logic [CFG_HEIGHT_W-1:0] cfg_height,
   output flag_type                flags,
   output logic [RPW-1:0]          hrep,
   output logic [RPW-1:0]          vrep,
   output logic [BW-1:0]           blk
);

   logic [CW-1:0]           col_ff, col_in;
   logic [CFG_HEIGHT_W-1:0] row_ff, row_in;
   logic [PW-1:0]           cph_ff, cph_in;
   logic [PW-1:0]           rph_ff, rph_in;
   logic [BW-1:0]           cblk_ff, cblk_in;
   logic [OUT_ROW_W-1:0]    rblk_ff, rblk_in;

   logic [31:0]             w_ext;
   logic [31:0]             w_lim32;
   logic [CW-1:0]           w_lim;
   logic [CFG_HEIGHT_W-1:0] h_lim;
   logic [31:0]             hrep32;
   logic [31:0]             vrep32;
   logic                    cph_wrap;
   logic                    rph_wrap;

   always_comb begin
      w_ext = 32'(cfg_width);
      if (w_ext == 32'd0) begin
         w_ext = 32'd1;
      end
      if (w_ext > 32'(MAX_WIDTH)) begin
         w_ext = 32'(MAX_WIDTH);
      end
      w_lim32 = w_ext - 32'd1;
      w_lim   = w_lim32[CW-1:0];
      h_lim   = (cfg_height == '0) ? '0 : cfg_height - CFG_HEIGHT_W'(1);

      cph_wrap = cph_ff >= PW'(SCALE - 1);
      rph_wrap = rph_ff >= PW'(SCALE - 1);

      flags.last_col  = col_ff >= w_lim;
      flags.last_row  = row_ff >= h_lim;
      flags.col_done  = flags.last_col || cph_wrap;
      flags.row_done  = flags.last_row || rph_wrap;
      flags.col_first = cph_ff == '0;
      flags.row_first = rph_ff == '0;
      flags.out_row   = rblk_ff;

      hrep32 = 32'(SCALE) - 32'(cph_ff);
      hrep   = hrep32[RPW-1:0];
      vrep32 = flags.last_row ? 32'(SCALE) - 32'(rph_ff) : 32'd1;
      vrep   = vrep32[RPW-1:0];
      blk    = cblk_ff;

      col_in  = col_ff;
      row_in  = row_ff;
      cph_in  = cph_ff;
      rph_in  = rph_ff;
      cblk_in = cblk_ff;
      rblk_in = rblk_ff;
      if (advance) begin
         if (flags.last_col) begin
            col_in  = '0;
            cph_in  = '0;
            cblk_in = '0;
            if (flags.last_row) begin
               row_in  = '0;
               rph_in  = '0;
               rblk_in = '0;
            end else begin
               row_in = row_ff + CFG_HEIGHT_W'(1);
               if (rph_wrap) begin
                  rph_in  = '0;
                  rblk_in = rblk_ff + OUT_ROW_W'(1);
               end else begin
                  rph_in = rph_ff + PW'(1);
               end
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (cph_wrap) begin
               cph_in  = '0;
               cblk_in = cblk_ff + BW'(1);
            end else begin
               cph_in = cph_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cph_ff  <= '0;
         rph_ff  <= '0;
         cblk_ff <= '0;
         rblk_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cph_ff  <= cph_in;
         rph_ff  <= rph_in;
         cblk_ff <= cblk_in;
         rblk_ff <= rblk_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (cph_ff <= PW'(SCALE - 1)) && (rph_ff <= PW'(SCALE - 1)))
      else $error("block phase out of range");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (advance && flags.last_col) |=> (col_ff == '0) && (cph_ff == '0) && (cblk_ff == '0))
      else $error("column state not cleared at end of row");

endmodule

[hw/rtl/boxavg_colsum.sv]
// Per-block-column sum memory, registered read with same-edge write bypass.
module boxavg_colsum import boxavg_pkg::*; #(
   parameter int DEPTH = 342,
   parameter int AW    = 9,
   parameter int DW    = 36
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;
   logic          byp_ff;
   logic [DW-1:0] bypd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff   <= mem[rd_addr];
         byp_ff  <= wr_en && (wr_addr == rd_addr);
         bypd_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? bypd_ff : rd_ff;

endmodule

[hw/rtl/boxavg_mean.sv]
// Block mean: divide each channel sum by SCALE*SCALE with a reciprocal multiply.
module boxavg_mean import boxavg_pkg::*; #(
   parameter int SCALE = SCALE_DEF,
   localparam int TW   = PIX_W + 2 * $clog2(SCALE)
) (
   input  logic [CH_N-1:0][TW-1:0]    tot,
   output logic [CH_N-1:0][PIX_W-1:0] avg
);

   localparam int DIV    = SCALE * SCALE;
   localparam int DIV_SH = TW + $clog2(DIV);
   localparam int MW     = TW + DIV_SH + 1;
   localparam logic [MW-1:0] RECIP = MW'((2 ** DIV_SH + DIV - 1) / DIV);

   logic [CH_N-1:0][MW-1:0] prod;
   logic [CH_N-1:0][MW-1:0] quot;

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         prod[c] = MW'(tot[c]) * RECIP;
         quot[c] = prod[c] >> DIV_SH;
         avg[c]  = quot[c][PIX_W-1:0];
      end
   end

endmodule

[hw/rtl/box_average_downscale_3x3.sv]
// Top level: CSR port, input register, sum pipeline and result register.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   red_or_gray, green, blue
//  rsp      out        rsp_valid / rsp_stall   avg_*, out_col, out_row, frame_end
//  csr      in         psel/penable/pready     paddr, pwdata, prdata
//
// One word per cycle while rsp_stall is low; a block's last word goes from the input register
// through the sum/memory read, block total and mean steps into the result register.
// The column-sum memory is read and written at most once per cycle; a same-address write and
// read on one edge is bypassed. Synchronous reset loads the CSR defaults, clears the counters
// and valids; the column-sum memory is filled by row phase zero of each block row.
// A held result stalls stage 2 only when its word carries a result; the input waits behind it.
module box_average_downscale_3x3 import boxavg_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int SCALE     = SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_red_or_gray,
   input  logic [PIX_W-1:0]      req_green,
   input  logic [PIX_W-1:0]      req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_avg_red_or_gray,
   output logic [PIX_W-1:0]      rsp_avg_green,
   output logic [PIX_W-1:0]      rsp_avg_blue,
   output logic [OUT_COL_W-1:0]  rsp_out_col,
   output logic [OUT_ROW_W-1:0]  rsp_out_row,
   output logic                  rsp_frame_end,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int RPW        = $clog2(SCALE + 1);
   localparam int BLOCK_COLS = (MAX_WIDTH + SCALE - 1) / SCALE;
   localparam int BW         = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
   localparam int HW         = PIX_W + $clog2(SCALE);
   localparam int TW         = PIX_W + 2 * $clog2(SCALE);

   // CSR
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic                    color_ff;
   logic                    csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         color_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[CFG_HEIGHT_W-1:0];
            REG_COLOR_MODE:   color_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_COLOR_MODE:   prdata = CSR_DATA_W'(color_ff);
         default:          prdata = '0;
      endcase
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic o_ready, s3_go, s2_go, s2_free, s1_go, s1_free, accept, emit2;

   flag_type                       flg1_ff, flg2_ff, scan_flags;
   logic [RPW-1:0]                 hrep1_ff, vrep1_ff, vrep2_ff, scan_hrep, scan_vrep;
   logic [BW-1:0]                  blk1_ff, blk2_ff, scan_blk;
   logic [CH_N-1:0][PIX_W-1:0]     px1_ff;
   logic [CH_N-1:0][HW-1:0]        part_ff, part_in, horiz_in, horiz2_ff;
   logic [CH_N-1:0][HW-1:0]        base;
   logic [CH_N-1:0][TW-1:0]        rd_sum, tot_in, tot3_ff;
   logic [CH_N*TW-1:0]             mem_rd_data;
   logic                           mem_we;
   logic [OUT_COL_W-1:0]           col3_ff;
   logic [OUT_ROW_W-1:0]           row3_ff;
   logic                           fend3_ff;
   logic [CH_N-1:0][PIX_W-1:0]     avg_in, avg_ff;
   logic [OUT_COL_W-1:0]           col_ff;
   logic [OUT_ROW_W-1:0]           row_ff;
   logic                           fend_ff;
   logic [31:0]                    blk_ext;

   assign emit2   = flg2_ff.col_done && flg2_ff.row_done;
   assign o_ready = !vo_ff || !rsp_stall;
   assign s3_go   = v3_ff && o_ready;
   assign s2_go   = v2_ff && (!emit2 || !v3_ff || o_ready);
   assign s2_free = !v2_ff || s2_go;
   assign s1_go   = v1_ff && s2_free;
   assign s1_free = !v1_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;
   assign mem_we    = s2_go && flg2_ff.col_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            v1_ff <= req_valid;
         end
         if (s2_free) begin
            v2_ff <= s1_go;
         end
         if (!v3_ff || o_ready) begin
            v3_ff <= s2_go && emit2;
         end
         if (o_ready) begin
            vo_ff <= v3_ff;
         end
      end
   end

   boxavg_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .SCALE     (SCALE)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .flags      (scan_flags),
      .hrep       (scan_hrep),
      .vrep       (scan_vrep),
      .blk        (scan_blk)
   );

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff[0] <= req_red_or_gray;
         px1_ff[1] <= color_ff ? req_green : '0;
         px1_ff[2] <= color_ff ? req_blue : '0;
         flg1_ff   <= scan_flags;
         hrep1_ff  <= scan_hrep;
         vrep1_ff  <= scan_vrep;
         blk1_ff   <= scan_blk;
      end
   end

   // horizontal sums, with right-edge replication
   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         base[c]     = flg1_ff.col_first ? '0 : part_ff[c];
         horiz_in[c] = base[c] + HW'(px1_ff[c]) * HW'(hrep1_ff);
         part_in[c]  = flg1_ff.col_done ? '0 : base[c] + HW'(px1_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         part_ff   <= part_in;
         horiz2_ff <= horiz_in;
         flg2_ff   <= flg1_ff;
         vrep2_ff  <= vrep1_ff;
         blk2_ff   <= blk1_ff;
      end
   end

   // stage 2: block totals, with bottom-edge replication
   boxavg_colsum #(
      .DEPTH (BLOCK_COLS),
      .AW    (BW),
      .DW    (CH_N * TW)
   ) u_colsum (
      .clock   (clock),
      .rd_en   (s1_go),
      .rd_addr (blk1_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_we),
      .wr_addr (blk2_ff),
      .wr_data (tot_in)
   );

   assign rd_sum = mem_rd_data;

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         tot_in[c] = (flg2_ff.row_first ? '0 : rd_sum[c]) + TW'(horiz2_ff[c]) * TW'(vrep2_ff);
      end
      blk_ext = 32'(blk2_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_go && emit2) begin
         tot3_ff  <= tot_in;
         col3_ff  <= blk_ext[OUT_COL_W-1:0];
         row3_ff  <= flg2_ff.out_row;
         fend3_ff <= flg2_ff.last_row && flg2_ff.last_col;
      end
   end

   // stage 3: mean into the result register
   boxavg_mean #(
      .SCALE (SCALE)
   ) u_mean (
      .tot (tot3_ff),
      .avg (avg_in)
   );

   always_ff @(posedge clock) begin
      if (s3_go) begin
         avg_ff  <= avg_in;
         col_ff  <= col3_ff;
         row_ff  <= row3_ff;
         fend_ff <= fend3_ff;
      end
   end

   assign rsp_valid           = vo_ff;
   assign rsp_avg_red_or_gray = avg_ff[0];
   assign rsp_avg_green       = avg_ff[1];
   assign rsp_avg_blue        = avg_ff[2];
   assign rsp_out_col         = col_ff;
   assign rsp_out_row         = row_ff;
   assign rsp_frame_end       = fend_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted word not in input register");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !s2_go) |=> v2_ff && $stable(horiz2_ff) && $stable(blk2_ff))
      else $error("stage 2 word changed while held");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !s3_go) |=> v3_ff && $stable(tot3_ff))
      else $error("stage 3 word changed while held");

endmodule
